// ===== hw/rtl/pmvm_pkg.sv =====
`default_nettype none

package pmvm_pkg;

  localparam int VALUE_BITS   = 48;
  localparam int COUNT_BITS   = 32;
  localparam int FRAC_DEFAULT = 16;

  typedef struct packed {
    logic                         first_set;
    logic [COUNT_BITS-1:0]        set_size;
    logic signed [VALUE_BITS-1:0] set_mean;
    logic [VALUE_BITS-1:0]        set_variance;
  } req_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]        out_count;
    logic signed [VALUE_BITS-1:0] out_mean;
    logic [VALUE_BITS-1:0]        out_variance;
    logic                         saturated;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pooled_mean_variance_merge.sv =====
`default_nettype none

// Channel  Direction  Handshake             Payload
// req      in         req_valid, req_stall  req_t: set flag, size, mean, variance
// rsp      out        rsp_valid, rsp_stall  rsp_t: count, mean, variance, saturated
//
// A set that starts a merge, or an empty set, goes straight from ST_IDLE to ST_FIN.
// A merge runs eight shift-add multiplies and three restoring divides on one
// shared accumulator; each multiply ends once its multiplier has shifted out, and a
// divide whose quotient cannot fit in VALUE_BITS saturates without iterating.
// Reset clears the running totals and the sequencer; rsp_stall holds the finished request
// in the result register, a new request is taken meanwhile, and its result waits in ST_FIN.

module pooled_mean_variance_merge
  import pmvm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_DEFAULT
) (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic req_valid,
  output logic       req_stall,
  input  wire  req_t req,
  output logic       rsp_valid,
  input  wire  logic rsp_stall,
  output rsp_t       rsp
);

  localparam int VB  = VALUE_BITS;
  localparam int CB  = COUNT_BITS;
  localparam int SW  = ((VB > CB) ? VB : CB) + 1;
  localparam int MPW = VB + CB;
  localparam int AW  = 3 * VB + CB;
  localparam int CW  = $clog2(VB + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SETUP = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_DCHK  = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    S_N1VA, S_M1VB, S_VAR1, S_DEN, S_NM, S_DD, S_NUM2, S_VAR2, S_P, S_Q, S_MEAN
  } step_t;

  typedef enum logic [1:0] {
    MODE_COPY, MODE_HOLD, MODE_MERGE
  } mode_t;

  state_t state;
  step_t  step;
  mode_t  mode;

  logic [VB-1:0] total_count, pooled_mean, pooled_variance;
  logic          sat_flag;

  logic [CB-1:0] m;
  logic [VB-1:0] b_mean, b_var;

  logic [AW-1:0]    acc, mc, dv, rem;
  logic [MPW-1:0]   mp;
  logic [VB-1:0]    nlo, quo;
  logic [CW-1:0]    cnt;
  logic             dovf, sat_acc, rneg;
  logic [VB-1:0]    r_var1, r_var2;
  logic [2*SW-1:0]  r_den;
  logic [MPW-1:0]   r_t;
  logic [2*VB:0]    r_t2;
  logic [2*VB-1:0]  r_p;

  logic [SW-1:0] sum, sum1;
  logic          aneg, bneg;
  logic [VB-1:0] amag, bmag;
  logic [VB:0]   d;
  logic [AW-1:0] p_ext, s_val;
  logic          p_ge, s_neg;
  logic [AW:0]   trial, trial_diff;
  logic          trial_ge, chk_ovf;
  logic [VB:0]   vsum;
  logic          cnt_ovf;

  logic [VB-1:0] count_next, mean_next, var_next;
  logic          sat_next;

  localparam logic [VB-1:0] VMASK = {VB{1'b1}};

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    sum  = SW'(total_count) + SW'(m);
    sum1 = sum - SW'(1);
    aneg = pooled_mean[VB-1];
    bneg = b_mean[VB-1];
    amag = aneg ? (~pooled_mean + VB'(1)) : pooled_mean;
    bmag = bneg ? (~b_mean + VB'(1)) : b_mean;
    if (aneg != bneg) begin
      d = {1'b0, amag} + {1'b0, bmag};
    end else if (amag >= bmag) begin
      d = {1'b0, amag - bmag};
    end else begin
      d = {1'b0, bmag - amag};
    end
    // Weighted mean numerator in sign-magnitude; acc holds m * |b| here.
    p_ext = AW'(r_p);
    p_ge  = (p_ext >= acc);
    if (aneg == bneg) begin
      s_val = p_ext + acc;
      s_neg = aneg;
    end else if (p_ge) begin
      s_val = p_ext - acc;
      s_neg = aneg;
    end else begin
      s_val = acc - p_ext;
      s_neg = bneg;
    end
    trial      = {rem, nlo[VB-1]};
    trial_ge   = (trial >= {1'b0, dv});
    trial_diff = trial - {1'b0, dv};
    chk_ovf    = ((acc >> VB) >= dv);
    vsum       = {1'b0, r_var1} + {1'b0, r_var2};
    cnt_ovf    = (sum > SW'(VMASK));
  end

  always_comb begin
    count_next = total_count;
    mean_next  = pooled_mean;
    var_next   = pooled_variance;
    sat_next   = sat_flag;
    unique case (mode)
      MODE_COPY: begin
        if (SW'(m) > SW'(VMASK)) begin
          count_next = VMASK;
          sat_next   = 1'b1;
        end else begin
          count_next = VB'(m);
          sat_next   = 1'b0;
        end
        mean_next = b_mean;
        var_next  = b_var;
      end
      MODE_MERGE: begin
        count_next = cnt_ovf ? VMASK : sum[VB-1:0];
        mean_next  = rneg ? (~quo + VB'(1)) : quo;
        var_next   = vsum[VB] ? VMASK : vsum[VB-1:0];
        sat_next   = sat_flag | sat_acc | vsum[VB] | cnt_ovf;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      step            <= S_N1VA;
      mode            <= MODE_HOLD;
      rsp_valid       <= 1'b0;
      total_count     <= '0;
      pooled_mean     <= '0;
      pooled_variance <= '0;
      sat_flag        <= 1'b0;
    end else begin
      // In ST_FIN a delivered result is replaced by the next one below.
      if (rsp_valid && !rsp_stall && state != ST_FIN) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            m       <= req.set_size;
            b_mean  <= req.set_mean;
            b_var   <= req.set_variance;
            sat_acc <= 1'b0;
            step    <= S_N1VA;
            if (req.first_set || total_count == '0) begin
              mode  <= MODE_COPY;
              state <= ST_FIN;
            end else if (req.set_size == '0) begin
              mode  <= MODE_HOLD;
              state <= ST_FIN;
            end else begin
              mode  <= MODE_MERGE;
              state <= ST_SETUP;
            end
          end
        end
        ST_SETUP: begin
          unique case (step)
            S_N1VA: begin
              acc   <= '0;
              mc    <= AW'(pooled_variance);
              mp    <= MPW'(total_count - VB'(1));
              state <= ST_MUL;
            end
            S_M1VB: begin
              mc    <= AW'(b_var);
              mp    <= MPW'(m - CB'(1));
              state <= ST_MUL;
            end
            S_VAR1: begin
              dv    <= AW'(sum1);
              state <= ST_DCHK;
            end
            S_DEN: begin
              acc   <= '0;
              mc    <= AW'(sum);
              mp    <= MPW'(sum1);
              state <= ST_MUL;
            end
            S_NM: begin
              acc   <= '0;
              mc    <= AW'(total_count);
              mp    <= MPW'(m);
              state <= ST_MUL;
            end
            S_DD: begin
              acc   <= '0;
              mc    <= AW'(d);
              mp    <= MPW'(d);
              state <= ST_MUL;
            end
            S_NUM2: begin
              acc   <= '0;
              mc    <= AW'(r_t2);
              mp    <= r_t;
              state <= ST_MUL;
            end
            S_VAR2: begin
              // The squared mean difference carries twice the fraction bits.
              dv    <= AW'(r_den) << FRAC_BITS;
              state <= ST_DCHK;
            end
            S_P: begin
              acc   <= '0;
              mc    <= AW'(total_count);
              mp    <= MPW'(amag);
              state <= ST_MUL;
            end
            S_Q: begin
              acc   <= '0;
              mc    <= AW'(m);
              mp    <= MPW'(bmag);
              state <= ST_MUL;
            end
            S_MEAN: begin
              acc   <= s_val;
              rneg  <= s_neg;
              dv    <= AW'(sum);
              state <= ST_DCHK;
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_MUL: begin
          if (mp != '0) begin
            if (mp[0]) begin
              acc <= acc + mc;
            end
            mc <= mc << 1;
            mp <= mp >> 1;
          end else begin
            unique case (step)
              S_N1VA: begin
                step  <= S_M1VB;
                state <= ST_SETUP;
              end
              S_M1VB: begin
                step  <= S_VAR1;
                state <= ST_SETUP;
              end
              S_DEN: begin
                r_den <= acc[2*SW-1:0];
                step  <= S_NM;
                state <= ST_SETUP;
              end
              S_NM: begin
                r_t   <= acc[MPW-1:0];
                step  <= S_DD;
                state <= ST_SETUP;
              end
              S_DD: begin
                r_t2  <= acc[2*VB:0];
                step  <= S_NUM2;
                state <= ST_SETUP;
              end
              S_NUM2: begin
                step  <= S_VAR2;
                state <= ST_SETUP;
              end
              S_P: begin
                r_p   <= acc[2*VB-1:0];
                step  <= S_Q;
                state <= ST_SETUP;
              end
              S_Q: begin
                step  <= S_MEAN;
                state <= ST_SETUP;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_DCHK: begin
          // A quotient that cannot fit in VALUE_BITS saturates at once.
          rem   <= acc >> VB;
          nlo   <= acc[VB-1:0];
          dovf  <= chk_ovf;
          cnt   <= chk_ovf ? '0 : CW'(VB);
          quo   <= chk_ovf ? VMASK : '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt != '0) begin
            rem <= trial_ge ? trial_diff[AW-1:0] : trial[AW-1:0];
            quo <= {quo[VB-2:0], trial_ge};
            nlo <= nlo << 1;
            cnt <= cnt - CW'(1);
          end else begin
            unique case (step)
              S_VAR1: begin
                r_var1  <= quo;
                sat_acc <= sat_acc | dovf;
                step    <= S_DEN;
                state   <= ST_SETUP;
              end
              S_VAR2: begin
                r_var2  <= quo;
                sat_acc <= sat_acc | dovf;
                step    <= S_P;
                state   <= ST_SETUP;
              end
              S_MEAN: state <= ST_FIN;
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            total_count      <= count_next;
            pooled_mean      <= mean_next;
            pooled_variance  <= var_next;
            sat_flag         <= sat_next;
            rsp.out_count    <= count_next;
            rsp.out_mean     <= mean_next;
            rsp.out_variance <= var_next;
            rsp.saturated    <= sat_next;
            rsp_valid        <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A delivered result is not shown again unless a new one is written.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall && state != ST_FIN) |=> !rsp_valid)
    else $error("result repeated");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL && mp == '0) |=> (state == ST_SETUP))
    else $error("multiply did not return to setup");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt == '0 && step == S_MEAN) |=> (state == ST_FIN))
    else $error("mean divide did not finish");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && mode == MODE_MERGE && sat_flag && (!rsp_valid || !rsp_stall))
    |=> sat_flag)
    else $error("saturation flag lost during merge");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
  import pmvm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [47:0] VMAX = {48{1'b1}};
  localparam int LIMIT = 4000000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // Running totals as the block should hold them.
  logic [47:0] tot_count;
  logic [47:0] run_mean;
  logic [47:0] run_var;
  logic        run_sat;

  rsp_t totals_q[$];
  int   errors;
  int   cycles;
  logic long_hold_req;
  logic quiet;

  pooled_mean_variance_merge i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [47:0] clip48(input logic [255:0] x, inout logic hit);
    if (x > {208'd0, VMAX}) begin
      hit = 1'b1;
      return VMAX;
    end
    return x[47:0];
  endfunction

  function automatic rsp_t merge_predict(input req_t r);
    logic [255:0] wn, wm, sum, sum1, num1, num2, den2, p, q, s, qm;
    logic [48:0]  amag, bmag, d;
    logic         aneg, bneg, rneg, hit;
    logic [47:0]  var1, var2;
    rsp_t         o;
    if (r.first_set || tot_count == 0) begin
      tot_count = {16'd0, r.set_size};
      run_sat = 1'b0;
      run_mean = r.set_mean;
      run_var = r.set_variance;
    end else if (r.set_size != 0) begin
      hit = 1'b0;
      wn = tot_count;
      wm = r.set_size;
      sum = wn + wm;
      sum1 = sum - 1;
      aneg = run_mean[47];
      amag = aneg ? {1'b0, -run_mean} : {1'b0, run_mean};
      if (aneg && amag == 0) amag = 49'd1 << 47;
      bneg = r.set_mean[47];
      bmag = bneg ? {1'b0, -r.set_mean} : {1'b0, r.set_mean};
      if (bneg && bmag == 0) bmag = 49'd1 << 47;
      num1 = (wn - 1) * run_var + (wm - 1) * r.set_variance;
      var1 = clip48(num1 / sum1, hit);
      if (aneg != bneg) d = amag + bmag;
      else d = (amag >= bmag) ? amag - bmag : bmag - amag;
      num2 = (wn * wm) * ({207'd0, d} * {207'd0, d});
      den2 = (sum * sum1) << FRAC_DEFAULT;
      var2 = clip48(num2 / den2, hit);
      run_var = clip48({208'd0, var1} + {208'd0, var2}, hit);
      p = wn * amag;
      q = wm * bmag;
      if (aneg == bneg) begin
        s = p + q;
        rneg = aneg;
      end else if (p >= q) begin
        s = p - q;
        rneg = aneg;
      end else begin
        s = q - p;
        rneg = bneg;
      end
      qm = s / sum;
      run_mean = rneg ? -qm[47:0] : qm[47:0];
      if (sum > {208'd0, VMAX}) begin
        tot_count = VMAX;
        hit = 1'b1;
      end else begin
        tot_count = sum[47:0];
      end
      if (hit) run_sat = 1'b1;
    end
    o.out_count = tot_count;
    o.out_mean = run_mean;
    o.out_variance = run_var;
    o.saturated = run_sat;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (totals_q.size() == 0) begin
        report_mismatch("unexpected result", rsp.out_count, 48'd0);
      end else begin
        want = totals_q.pop_front();
        if (rsp.out_count !== want.out_count)
          report_mismatch("count", rsp.out_count, want.out_count);
        if (rsp.out_mean !== want.out_mean)
          report_mismatch("mean", rsp.out_mean, want.out_mean);
        if (rsp.out_variance !== want.out_variance)
          report_mismatch("variance", rsp.out_variance, want.out_variance);
        if (rsp.saturated !== want.saturated)
          report_mismatch("saturated", {47'd0, rsp.saturated}, {47'd0, want.saturated});
      end
    end
  end

  // Result side: a random stall before each result, or one long hold on request.
  initial begin
    int k;
    rsp_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (3000) @(negedge clk);
      end
      k = quiet ? 0 : $urandom_range(0, 4);
      if (k != 0) begin
        rsp_stall <= 1'b1;
        repeat (k) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_set(input logic first, input logic [31:0] size,
                          input logic [47:0] mean, input logic [47:0] variance);
    int gap;
    req_t r;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    r.first_set = first;
    r.set_size = size;
    r.set_mean = mean;
    r.set_variance = variance;
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    totals_q.push_back(merge_predict(r));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (totals_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(0, 65535)), $urandom()};
  endfunction

  task automatic test_directed();
    // Empty first set, then a merge that must act as a fresh start.
    send_set(1'b1, 32'd0, 48'd5, 48'd7);
    send_set(1'b0, 32'd3, 48'h0000_0001_0000, 48'h0000_0002_0000);
    send_set(1'b0, 32'd1, 48'h0000_0003_0000, 48'd0);
    // Empty set while merging repeats the totals.
    send_set(1'b0, 32'd0, rand48(), rand48());
    // Extreme means and variances, with variance overflow.
    send_set(1'b1, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF, VMAX);
    send_set(1'b0, 32'hFFFF_FFFF, 48'h8000_0000_0000, VMAX);
    send_set(1'b0, 32'd1, 48'h8000_0000_0000, 48'd0);
    send_set(1'b1, 32'd1, 48'h8000_0000_0000, 48'd0);
    send_set(1'b0, 32'd1, 48'h8000_0000_0000, 48'd0);
    send_set(1'b0, 32'd2, 48'h7FFF_FFFF_FFFF, VMAX);
    send_set(1'b1, 32'd1, 48'd0, 48'd0);
    send_set(1'b0, 32'd1, 48'd0, 48'd0);
    send_set(1'b0, 32'd100, VMAX, 48'h0000_0001_0000);
    send_set(1'b0, 32'hFFFF_FFFF, 48'h0000_0010_0000, 48'h0000_0100_0000);
    send_set(1'b1, 32'd4, 48'hFFFF_FFFF_0000, 48'h5555_5555_5555);
    send_set(1'b0, 32'd7, 48'h0000_0001_8000, 48'hAAAA_AAAA_AAAA);
    wait_drained();
  endtask

  task automatic test_long_hold();
    long_hold_req = 1'b1;
    send_set(1'b1, 32'd10, rand48(), rand48());
    for (int i = 0; i < 12; i++)
      send_set(1'b0, $urandom_range(1, 50), rand48(), rand48());
    wait_drained();
  endtask

  task automatic test_random();
    int len;
    logic [31:0] size;
    logic [47:0] mean;
    logic [47:0] variance;
    for (int sent = 0; sent < 1400;) begin
      quiet = ($urandom_range(0, 9) == 0);
      len = $urandom_range(2, 10);
      for (int j = 0; j < len; j++) begin
        case ($urandom_range(0, 9))
          0: size = $urandom();
          1: size = 32'd0;
          2, 3: size = $urandom_range(1, 65535);
          default: size = $urandom_range(1, 20);
        endcase
        if ($urandom_range(0, 2) == 0) begin
          mean = rand48();
          variance = rand48();
        end else begin
          mean = {{24{$urandom_range(0, 1) == 1}}, 24'($urandom())};
          variance = 48'($urandom_range(0, 32'h00FF_FFFF));
        end
        // Mostly one start followed by merges; now and then a stray restart.
        send_set(j == 0 || $urandom_range(0, 19) == 0, size, mean, variance);
        sent++;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    long_hold_req = 1'b0;
    tot_count = '0;
    run_mean = '0;
    run_var = '0;
    run_sat = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_long_hold();
    test_random();
    req_valid <= 1'b0;
    while (totals_q.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (errors == 0 && totals_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/pmvm_pkg.sv
hw/rtl/pooled_mean_variance_merge.sv
dv/tb.sv
